/* sv/rtc3w_pkg.sv */
// Shared types and constants for the three-wire real-time-clock bus master.
`timescale 1ns / 1ps

package rtc3w_pkg;

  // Sequencer phase codes.
  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_SETUP     = 3'd1;
  localparam logic [2:0] PH_SEND_HIGH = 3'd2;
  localparam logic [2:0] PH_SEND_LOW  = 3'd3;
  localparam logic [2:0] PH_READ_LOW  = 3'd4;
  localparam logic [2:0] PH_READ_HIGH = 3'd5;

  // Configuration register indexes.
  localparam logic [1:0] CFG_TICKS_PER_UNIT   = 2'd0;
  localparam logic [1:0] CFG_SETUP_UNITS      = 2'd1;
  localparam logic [1:0] CFG_CLOCK_HIGH_UNITS = 2'd2;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [7:0] TICKS_PER_UNIT_RST   = 8'd8;
  localparam logic [7:0] SETUP_UNITS_RST      = 8'd5;
  localparam logic [7:0] CLOCK_HIGH_UNITS_RST = 8'd1;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;

  // Bits per transaction: command byte, then data byte.
  localparam logic [4:0] CMD_BITS   = 5'd8;
  localparam logic [4:0] TOTAL_BITS = 5'd16;

  typedef struct packed {
    logic [7:0] ticks_per_unit;
    logic [7:0] setup_units;
    logic [7:0] clock_high_units;
  } cfg_t;

  // Last field in the lowest bits.
  typedef struct packed {
    logic       io_sample;
    logic [7:0] write_data;
    logic [7:0] reg_address;
    logic       func;
    logic       start_req;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       done_res;
    logic       busy_res;
    logic       io_drive;
    logic       io_level;
    logic       serial_clock;
    logic       chip_enable;
  } res_t;

  localparam int RES_W = $bits(res_t);

endpackage

/* sv/rtc3w_cfg.sv */
// Configuration register file of the three-wire bus master.
`timescale 1ns / 1ps

module rtc3w_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               wr_en,
  input  logic [rtc3w_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [rtc3w_pkg::CFG_DATA_W-1:0]   wr_data,
  output rtc3w_pkg::cfg_t                    cfg
);

  rtc3w_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ticks_per_unit   <= rtc3w_pkg::TICKS_PER_UNIT_RST;
      cfg_r.setup_units      <= rtc3w_pkg::SETUP_UNITS_RST;
      cfg_r.clock_high_units <= rtc3w_pkg::CLOCK_HIGH_UNITS_RST;
    end else if (wr_en) begin
      case (wr_index)
        rtc3w_pkg::CFG_TICKS_PER_UNIT:   cfg_r.ticks_per_unit   <= wr_data;
        rtc3w_pkg::CFG_SETUP_UNITS:      cfg_r.setup_units      <= wr_data;
        rtc3w_pkg::CFG_CLOCK_HIGH_UNITS: cfg_r.clock_high_units <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

/* sv/rtc3w_seq.sv */
// Tick sequencer: bus state and the pin levels that each tick produces.
`timescale 1ns / 1ps

module rtc3w_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  rtc3w_pkg::item_t   item,
  input  rtc3w_pkg::cfg_t    cfg,
  output rtc3w_pkg::res_t    res
);

  logic [2:0]  phase_r, phase_nxt;
  logic [3:0]  bit_index_r, bit_index_nxt;
  logic [15:0] out_shift_r, out_shift_nxt;
  logic [7:0]  in_shift_r, in_shift_nxt;
  logic [15:0] tick_count_r, tick_count_nxt;
  logic        is_write_r, is_write_nxt;
  logic        clock_level_r, clock_level_nxt;

  logic [7:0]  unit;
  logic [7:0]  high_units;
  logic [15:0] high_reload;
  logic [15:0] setup_ticks;
  logic [4:0]  bit_next;
  logic [7:0]  cmd;
  logic        done;
  logic        busy;
  logic        drive;

  always_comb begin
    // Zero unit or high counts behave as one.
    unit        = (cfg.ticks_per_unit == 8'd0) ? 8'd1 : cfg.ticks_per_unit;
    high_units  = (cfg.clock_high_units == 8'd0) ? 8'd1 : cfg.clock_high_units;
    high_reload = 16'(16'(high_units) * 16'(unit)) - 16'd1;
    setup_ticks = 16'(16'(cfg.setup_units) * 16'(unit));
    bit_next    = {1'b0, bit_index_r} + 5'd1;
    cmd         = item.func ? {item.reg_address[7:1], 1'b0}
                            : {item.reg_address[7:1], 1'b1};

    phase_nxt       = phase_r;
    bit_index_nxt   = bit_index_r;
    out_shift_nxt   = out_shift_r;
    in_shift_nxt    = in_shift_r;
    tick_count_nxt  = tick_count_r;
    is_write_nxt    = is_write_r;
    clock_level_nxt = clock_level_r;
    done            = 1'b0;

    case (phase_r)
      rtc3w_pkg::PH_SETUP: begin
        if (tick_count_r == 16'd0) begin
          phase_nxt       = rtc3w_pkg::PH_SEND_HIGH;
          clock_level_nxt = 1'b1;
          tick_count_nxt  = high_reload;
        end else begin
          tick_count_nxt = tick_count_r - 16'd1;
        end
      end
      rtc3w_pkg::PH_SEND_HIGH: begin
        if (tick_count_r == 16'd0) begin
          clock_level_nxt = 1'b0;
          out_shift_nxt   = {1'b0, out_shift_r[15:1]};
          if (bit_next == rtc3w_pkg::CMD_BITS && !is_write_r) begin
            phase_nxt     = rtc3w_pkg::PH_READ_LOW;
            bit_index_nxt = bit_next[3:0];
          end else if (bit_next >= rtc3w_pkg::TOTAL_BITS) begin
            // Last data bit of a write: chip enable drops here.
            phase_nxt     = rtc3w_pkg::PH_IDLE;
            bit_index_nxt = 4'd0;
            done          = 1'b1;
          end else begin
            phase_nxt     = rtc3w_pkg::PH_SEND_LOW;
            bit_index_nxt = bit_next[3:0];
          end
        end else begin
          tick_count_nxt = tick_count_r - 16'd1;
        end
      end
      rtc3w_pkg::PH_SEND_LOW: begin
        phase_nxt       = rtc3w_pkg::PH_SEND_HIGH;
        clock_level_nxt = 1'b1;
        tick_count_nxt  = high_reload;
      end
      rtc3w_pkg::PH_READ_LOW: begin
        in_shift_nxt = {item.io_sample, in_shift_r[7:1]};
        if (bit_next >= rtc3w_pkg::TOTAL_BITS) begin
          phase_nxt     = rtc3w_pkg::PH_IDLE;
          bit_index_nxt = 4'd0;
          done          = 1'b1;
        end else begin
          bit_index_nxt   = bit_next[3:0];
          phase_nxt       = rtc3w_pkg::PH_READ_HIGH;
          clock_level_nxt = 1'b1;
        end
      end
      rtc3w_pkg::PH_READ_HIGH: begin
        phase_nxt       = rtc3w_pkg::PH_READ_LOW;
        clock_level_nxt = 1'b0;
      end
      default: begin
        // Idle, and any code without meaning.
        phase_nxt       = rtc3w_pkg::PH_IDLE;
        clock_level_nxt = 1'b0;
        if (item.start_req) begin
          out_shift_nxt  = {item.write_data, cmd};
          is_write_nxt   = item.func;
          bit_index_nxt  = 4'd0;
          tick_count_nxt = setup_ticks;
          phase_nxt      = rtc3w_pkg::PH_SETUP;
        end
      end
    endcase

    busy  = (phase_nxt != rtc3w_pkg::PH_IDLE);
    drive = (phase_nxt == rtc3w_pkg::PH_SETUP) ||
            (phase_nxt == rtc3w_pkg::PH_SEND_HIGH) ||
            (phase_nxt == rtc3w_pkg::PH_SEND_LOW);

    res.chip_enable  = busy;
    res.serial_clock = busy & clock_level_nxt;
    res.io_level     = drive & out_shift_nxt[0];
    res.io_drive     = drive;
    res.busy_res     = busy;
    res.done_res     = done;
    res.read_data    = in_shift_nxt;

    if (!busy) begin
      clock_level_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= rtc3w_pkg::PH_IDLE;
      bit_index_r   <= 4'd0;
      out_shift_r   <= 16'd0;
      in_shift_r    <= 8'd0;
      tick_count_r  <= 16'd0;
      is_write_r    <= 1'b0;
      clock_level_r <= 1'b0;
    end else if (step) begin
      phase_r       <= phase_nxt;
      bit_index_r   <= bit_index_nxt;
      out_shift_r   <= out_shift_nxt;
      in_shift_r    <= in_shift_nxt;
      tick_count_r  <= tick_count_nxt;
      is_write_r    <= is_write_nxt;
      clock_level_r <= clock_level_nxt;
    end
  end

endmodule

/* sv/rtc3w_obuf.sv */
// Result register with a skid stage, so the input side keeps flowing under stall.
`timescale 1ns / 1ps

module rtc3w_obuf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rtc3w_pkg::res_t   push_data,
  output logic              can_push,
  output logic              out_valid,
  input  logic              out_ready,
  output rtc3w_pkg::res_t   out_data
);

  logic            main_valid_r;
  logic            skid_valid_r;
  rtc3w_pkg::res_t main_data_r;
  rtc3w_pkg::res_t skid_data_r;
  logic            pop;

  assign pop      = main_valid_r & out_ready;
  assign can_push = ~skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!main_valid_r || pop) begin
      if (skid_valid_r) begin
        main_valid_r <= 1'b1;
        skid_valid_r <= push;
      end else begin
        main_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid_r || pop) begin
      if (skid_valid_r) begin
        main_data_r <= skid_data_r;
        skid_data_r <= push_data;
      end else begin
        main_data_r <= push_data;
      end
    end else if (push) begin
      skid_data_r <= push_data;
    end
  end

  assign out_valid = main_valid_r;
  assign out_data  = main_data_r;

endmodule

/* sv/rtc_three_wire_master_core.sv */
// Top level of the three-wire real-time-clock bus master.
`timescale 1ns / 1ps
// The result of an accepted tick beat is registered in the result buffer before it is shown.
// Throughput: one tick beat per cycle while the skid entry is free; state advances once per accepted beat.
// A two-entry result buffer (register plus skid) keeps input ready while one result stalls.
// Reset (synchronous, active low) returns the bus to idle with all pins released
// and the configuration registers to 8, 5 and 1.

module rtc_three_wire_master_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Tick input channel.
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // tdata, low bit up: start_req[0], reg_address[8:1], write_data[16:9],
  // io_sample[17], zero fill [23:18].
  input  logic [rtc3w_pkg::IN_TDATA_W-1:0]     in_tdata,
  // tuser: func[0] (0 read, 1 write).
  input  logic                                 in_tuser,
  // Result channel.
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // tdata, low bit up: chip_enable[0], serial_clock[1], io_level[2], io_drive[3],
  // busy_res[4], done_res[5], read_data[13:6], zero fill [15:14].
  output logic [rtc3w_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // Configuration write channel; always ready.
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rtc3w_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rtc3w_pkg::CFG_DATA_W-1:0]     cfg_data
);

  rtc3w_pkg::cfg_t  cfg;
  rtc3w_pkg::item_t item;
  rtc3w_pkg::res_t  res;
  rtc3w_pkg::res_t  out_res;
  logic             in_accept;
  logic             can_push;

  assign cfg_ready = 1'b1;

  // Unpack the input beat; the command fields are only looked at in idle.
  assign item.start_req   = in_tdata[0];
  assign item.func        = in_tuser;
  assign item.reg_address = in_tdata[8:1];
  assign item.write_data  = in_tdata[16:9];
  assign item.io_sample   = in_tdata[17];

  assign in_tready = can_push;
  assign in_accept = in_tvalid & can_push;

  rtc3w_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Each accepted beat is one timebase tick of the bus sequencer.
  rtc3w_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (in_accept),
    .item  (item),
    .cfg   (cfg),
    .res   (res)
  );

  rtc3w_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept),
    .push_data (res),
    .can_push  (can_push),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res)
  );

  assign out_tdata = {{(rtc3w_pkg::OUT_TDATA_W - rtc3w_pkg::RES_W){1'b0}}, out_res};

endmodule

/* sv/rtc3w_checker.sv */
// Port-level checks for the three-wire bus master, bound to the top level.
`timescale 1ns / 1ps

module rtc3w_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [rtc3w_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // Nothing is shown right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // A finishing tick already shows the bus released.
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[5] |-> !out_tdata[4] && !out_tdata[0] && !out_tdata[3])
    else $error("done shown while bus still busy");

  // Serial clock and driven data only under chip enable.
  a_clock_under_ce: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1] || out_tdata[3]) |-> out_tdata[0])
    else $error("bus activity without chip enable");

  // A high data level is only ever driven, never floating.
  a_level_driven: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2] |-> out_tdata[3])
    else $error("data level set while pin released");

endmodule

bind rtc_three_wire_master_core rtc3w_checker u_rtc3w_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

/* tb/tb_rtc_three_wire_master_core.sv */
// Self-checking testbench for the three-wire real-time-clock bus master core.
`timescale 1ns / 1ps

module tb_rtc_three_wire_master_core;
  import rtc3w_pkg::*;

  // Generous bound on the whole run, far above the slowest correct run.
  localparam int CYCLE_LIMIT = 300000;
  // Index 3 decodes to no register; the block must ignore a write to it.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;
  // Width of the packed tick fields inside in_tdata, below the zero fill.
  localparam int TICK_FIELDS_W = 18;
  localparam int TICKS_PER_PHASE = 33;
  localparam int MAX_REPORTS = 100;

  // How the sampled IO pin behaves while a directed transaction runs.
  typedef enum {IO_ZERO, IO_ONE, IO_RAND} io_pattern_t;

  // Predicts the pin levels after every tick and checks them in order.
  class pin_scoreboard;
    cfg_t       regs;
    logic [2:0] phase;
    logic [3:0] bit_index;
    logic [15:0] out_shift;
    logic [7:0] in_shift;
    logic [15:0] tick_count;
    logic       is_write;
    logic       clock_level;
    res_t       expected_pins[$];
    int         errors;
    int         reported;

    function new();
      regs.ticks_per_unit   = TICKS_PER_UNIT_RST;
      regs.setup_units      = SETUP_UNITS_RST;
      regs.clock_high_units = CLOCK_HIGH_UNITS_RST;
      phase       = PH_IDLE;
      bit_index   = '0;
      out_shift   = '0;
      in_shift    = '0;
      tick_count  = '0;
      is_write    = 1'b0;
      clock_level = 1'b0;
      errors      = 0;
      reported    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_TICKS_PER_UNIT:   regs.ticks_per_unit = val;
        CFG_SETUP_UNITS:      regs.setup_units = val;
        CFG_CLOCK_HIGH_UNITS: regs.clock_high_units = val;
        default: ;
      endcase
    endfunction

    // A zero unit length counts as one tick.
    function logic [15:0] unit_ticks();
      return (regs.ticks_per_unit == 8'd0) ? 16'd1 : {8'd0, regs.ticks_per_unit};
    endfunction

    function logic [15:0] high_reload();
      logic [15:0] units;
      units = (regs.clock_high_units == 8'd0) ? 16'd1 : {8'd0, regs.clock_high_units};
      return units * unit_ticks() - 16'd1;
    endfunction

    function bit is_idle();
      return phase == PH_IDLE;
    endfunction

    function int pending();
      return expected_pins.size();
    endfunction

    // Advance the sequencer by one accepted tick and queue the pins it shows.
    function void note_tick(item_t t);
      logic [4:0] next_bit;
      logic       done;
      logic       busy;
      logic       drive;
      res_t       pins;
      done = 1'b0;
      next_bit = {1'b0, bit_index} + 5'd1;
      case (phase)
        PH_SETUP: begin
          if (tick_count == 16'd0) begin
            phase = PH_SEND_HIGH;
            clock_level = 1'b1;
            tick_count = high_reload();
          end else begin
            tick_count = tick_count - 16'd1;
          end
        end
        PH_SEND_HIGH: begin
          if (tick_count == 16'd0) begin
            clock_level = 1'b0;
            out_shift = out_shift >> 1;
            if (next_bit == CMD_BITS && !is_write) begin
              phase = PH_READ_LOW;
              bit_index = next_bit[3:0];
            end else if (next_bit >= TOTAL_BITS) begin
              phase = PH_IDLE;
              bit_index = '0;
              done = 1'b1;
            end else begin
              phase = PH_SEND_LOW;
              bit_index = next_bit[3:0];
            end
          end else begin
            tick_count = tick_count - 16'd1;
          end
        end
        PH_SEND_LOW: begin
          phase = PH_SEND_HIGH;
          clock_level = 1'b1;
          tick_count = high_reload();
        end
        PH_READ_LOW: begin
          in_shift = {t.io_sample, in_shift[7:1]};
          if (next_bit >= TOTAL_BITS) begin
            phase = PH_IDLE;
            bit_index = '0;
            done = 1'b1;
          end else begin
            bit_index = next_bit[3:0];
            phase = PH_READ_HIGH;
            clock_level = 1'b1;
          end
        end
        PH_READ_HIGH: begin
          phase = PH_READ_LOW;
          clock_level = 1'b0;
        end
        default: begin
          phase = PH_IDLE;
          clock_level = 1'b0;
          if (t.start_req) begin
            // The command LSB carries the direction: 0 for a write, 1 for a read.
            out_shift = {t.write_data,
                         t.func ? (t.reg_address & 8'hFE) : (t.reg_address | 8'h01)};
            is_write = t.func;
            bit_index = '0;
            tick_count = {8'd0, regs.setup_units} * unit_ticks();
            phase = PH_SETUP;
          end
        end
      endcase
      busy  = (phase != PH_IDLE);
      drive = (phase == PH_SETUP) || (phase == PH_SEND_HIGH) || (phase == PH_SEND_LOW);
      pins.chip_enable  = busy;
      pins.serial_clock = busy & clock_level;
      pins.io_level     = drive & out_shift[0];
      pins.io_drive     = drive;
      pins.busy_res     = busy;
      pins.done_res     = done;
      pins.read_data    = in_shift;
      if (!busy) clock_level = 1'b0;
      expected_pins.push_back(pins);
    endfunction

    function void report(string what, logic [7:0] want, logic [7:0] got);
      errors++;
      if (reported < MAX_REPORTS) begin
        reported++;
        $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
      end
    endfunction

    function void check_pins(logic [OUT_TDATA_W-1:0] tdata);
      res_t got;
      res_t want;
      got = tdata[RES_W-1:0];
      if (expected_pins.size() == 0) begin
        report("result beat with nothing pending, tdata", 8'h00, got[7:0]);
        return;
      end
      want = expected_pins.pop_front();
      if (got.chip_enable !== want.chip_enable)
        report("chip_enable", want.chip_enable, got.chip_enable);
      if (got.serial_clock !== want.serial_clock)
        report("serial_clock", want.serial_clock, got.serial_clock);
      if (got.io_level !== want.io_level)
        report("io_level", want.io_level, got.io_level);
      if (got.io_drive !== want.io_drive)
        report("io_drive", want.io_drive, got.io_drive);
      if (got.busy_res !== want.busy_res)
        report("busy_res", want.busy_res, got.busy_res);
      if (got.done_res !== want.done_res)
        report("done_res", want.done_res, got.done_res);
      if (got.read_data !== want.read_data)
        report("read_data", want.read_data, got.read_data);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Percent of cycles in which the sender holds back a beat and in which
  // the receiver drops out_tready. The stimulus walks through three mixes.
  int send_idle_pct = 11;
  int ready_stall_pct = 56;
  int cycle_count = 0;

  pin_scoreboard sb = new();

  rtc_three_wire_master_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Result side. Values read right after the edge are the ones the block
  // presented before it, so a beat counts when both were high there. The
  // ready for the next cycle is then chosen with a single nonblocking write.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_pins(out_tdata);
    out_tready <= ($urandom_range(0, 99) >= ready_stall_pct);
  end

  function automatic item_t random_item();
    item_t t;
    t.start_req   = $urandom_range(0, 1);
    t.func        = $urandom_range(0, 1);
    t.reg_address = $urandom_range(0, 255);
    t.write_data  = $urandom_range(0, 255);
    t.io_sample   = $urandom_range(0, 1);
    return t;
  endfunction

  // Offer one tick beat, after a random number of idle cycles, and hand it
  // to the predictor once the block takes it. tvalid stays high between
  // back-to-back beats, so it is never lowered and raised in one step.
  task automatic send_tick(item_t t);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W - TICK_FIELDS_W){1'b0}},
                  t.io_sample, t.write_data, t.reg_address, t.start_req};
    in_tuser  <= t.func;
    do @(posedge clk); while (!in_tready);
    sb.note_tick(t);
  endtask

  // Stop sending and wait until every pending result beat has been checked.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Registers are only touched with the result pipeline empty. The bus
  // sequencer itself may still be mid-transaction, which is legal: a delay
  // already counting keeps its length and later delays use the new values.
  task automatic set_config(logic [7:0] tpu, logic [7:0] setup, logic [7:0] high);
    drain();
    cfg_write(CFG_TICKS_PER_UNIT, tpu);
    cfg_write(CFG_SETUP_UNITS, setup);
    cfg_write(CFG_CLOCK_HIGH_UNITS, high);
  endtask

  // Feed ticks until the predicted sequencer is idle again. With busy_start
  // set every tick also requests a start, which the block must ignore,
  // including on the tick that finishes the transaction.
  task automatic finish_txn(io_pattern_t io, bit busy_start);
    item_t t;
    while (!sb.is_idle()) begin
      t = random_item();
      t.start_req = busy_start;
      case (io)
        IO_ZERO: t.io_sample = 1'b0;
        IO_ONE:  t.io_sample = 1'b1;
        default: ;
      endcase
      send_tick(t);
    end
  endtask

  task automatic run_txn(logic wr, logic [7:0] addr, logic [7:0] data,
                         io_pattern_t io, bit busy_start);
    item_t t;
    t = random_item();
    t.start_req   = 1'b1;
    t.func        = wr;
    t.reg_address = addr;
    t.write_data  = data;
    send_tick(t);
    finish_txn(io, busy_start);
  endtask

  // Random ticks: when idle a start follows almost at once, so most ticks
  // land inside well-formed transactions; while busy some ticks carry a
  // stray start and every field is random, the IO samples included.
  task automatic random_ticks(int count);
    item_t t;
    for (int i = 0; i < count; i++) begin
      t = random_item();
      t.start_req = sb.is_idle() ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 4) == 0);
      send_tick(t);
    end
  endtask

  initial begin
    item_t t;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, on the reset configuration first. A write with an
    // all-ones command shows the LSB forced low, while ignored starts ride
    // on every busy tick; a read of an all-zero command shows it forced high.
    run_txn(1'b1, 8'hFF, 8'h00, IO_RAND, 1'b1);
    run_txn(1'b0, 8'h00, 8'hFF, IO_ONE, 1'b0);

    // Shortest timing, with no setup delay at all.
    set_config(8'd1, 8'd0, 8'd1);
    run_txn(1'b1, 8'h00, 8'hFF, IO_RAND, 1'b0);
    run_txn(1'b0, 8'hFE, 8'h5A, IO_ZERO, 1'b1);

    // Zero unit and clock-high lengths fall back to one; a long setup; a
    // write to the unused index must change nothing.
    set_config(8'd0, 8'd60, 8'd0);
    cfg_write(CFG_UNUSED_INDEX, 8'hFF);
    run_txn(1'b0, 8'hA5, 8'h3C, IO_RAND, 1'b0);

    // A longer delay unit, then a longer clock-high time.
    set_config(8'd3, 8'd0, 8'd1);
    run_txn(1'b1, 8'h81, 8'h7E, IO_RAND, 1'b0);
    set_config(8'd1, 8'd1, 8'd4);
    run_txn(1'b0, 8'h42, 8'h00, IO_RAND, 1'b1);

    // Registers rewritten while a transaction is partway through its bits.
    set_config(8'd2, 8'd3, 8'd2);
    run_txn(1'b1, 8'hC3, 8'h96, IO_RAND, 1'b0);
    t = random_item();
    t.start_req = 1'b1;
    t.func = 1'b1;
    send_tick(t);
    for (int i = 0; i < 12; i++) begin
      t = random_item();
      t.start_req = 1'b0;
      send_tick(t);
    end
    set_config(8'd1, 8'd0, 8'd3);
    finish_txn(IO_RAND, 1'b0);

    // Random part: three idling mixes, each over several small timings so
    // that many transactions fit in the run.
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle_pct = 11;
          ready_stall_pct = 56;
        end
        1: begin
          send_idle_pct = 56;
          ready_stall_pct = 11;
        end
        default: begin
          send_idle_pct = 0;
          ready_stall_pct = 0;
        end
      endcase
      for (int k = 0; k < 3; k++) begin
        set_config($urandom_range(0, 3), $urandom_range(0, 4), $urandom_range(0, 3));
        random_ticks(TICKS_PER_PHASE);
      end
    end

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* files.f */
sv/rtc3w_pkg.sv
sv/rtc3w_cfg.sv
sv/rtc3w_seq.sv
sv/rtc3w_obuf.sv
sv/rtc_three_wire_master_core.sv
sv/rtc3w_checker.sv
tb/tb_rtc_three_wire_master_core.sv
